>>> rtl/core/bfr_pkg.sv
// Shared types and constants for the battery frame receiver.
`default_nettype none

package bfr_pkg;

  localparam int unsigned HEADER_LEN  = 8;
  localparam int unsigned PAYLOAD_LEN = 24;
  localparam int unsigned WORD_COUNT  = 6;
  localparam int unsigned COUNT_W     = $clog2(PAYLOAD_LEN + 1);

  // Header bytes, first received byte in the top byte.
  localparam logic [8*HEADER_LEN-1:0] HEADER_WORD = 64'h2441_5556_3230_3030;

  typedef struct packed {
    logic shift;
    logic clear;
  } hdr_ctl_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_CHECK   = 3'b100
  } phase_t;

  // 8-bit sum of the header bytes, seeds the running checksum.
  function automatic logic [7:0] header_sum();
    logic [7:0] s;
    s = 8'd0;
    for (int i = 0; i < HEADER_LEN; i++) begin
      s = s + HEADER_WORD[8*i +: 8];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bfr_hdr_det.sv
// Header detector: sliding window over the last eight hunted bytes.
`default_nettype none

module bfr_hdr_det
  import bfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire hdr_ctl_t ctl,
  input  wire logic [7:0] rx_byte,
  output logic          match
);

  logic [8*HEADER_LEN-1:0] recent;
  logic [8*HEADER_LEN-1:0] recent_next;

  assign recent_next = {recent[8*HEADER_LEN-9:0], rx_byte};
  assign match       = ctl.shift && (recent_next == HEADER_WORD);

  // window is wiped on a match so header bytes never count twice
  always_ff @(posedge clk) begin
    if (rst) begin
      recent <= '0;
    end else if (ctl.clear || match) begin
      recent <= '0;
    end else if (ctl.shift) begin
      recent <= recent_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/battery_frame_receiver.sv
// Battery frame receiver: hunts for the 8-byte header, gathers 24 payload bytes as six
// little-endian words, checks the two's-complement checksum byte and reports each frame end.
// One byte is taken per cycle while in_ready is high; every byte is handled in the cycle it is
// transferred and a result, issued only for the checksum byte, appears in the output register
// on the next cycle. The output register decouples the two sides: in_ready is low only while a
// result waits to be taken. The six words hold the last good frame (zero after reset).
`default_nettype none

module battery_frame_receiver
  import bfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             frame_ok,
  output logic [31:0]      total_raw,
  output logic [31:0]      capacity_raw,
  output logic [31:0]      used_raw,
  output logic [31:0]      percentage_raw,
  output logic [31:0]      current_raw,
  output logic [31:0]      voltage_raw
);

  phase_t                     phase;
  phase_t                     phase_next;
  logic [COUNT_W-1:0]         byte_count;
  logic [COUNT_W-1:0]         byte_count_next;
  logic [7:0]                 running_sum;
  logic [7:0]                 running_sum_next;
  logic [8*PAYLOAD_LEN-1:0]   payload;
  logic [32*WORD_COUNT-1:0]   saved;
  logic                       accept;
  logic                       sum_ok;
  logic                       hdr_match;
  logic                       result;
  hdr_ctl_t                   hdr_ctl;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign sum_ok   = (rx_byte == 8'(8'd0 - running_sum));

  always_comb begin
    hdr_ctl.shift = 1'b0;
    hdr_ctl.clear = 1'b0;
    unique case (phase)
      PH_PAYLOAD: ;
      PH_CHECK:   hdr_ctl.clear = accept;
      default:    hdr_ctl.shift = accept;
    endcase
  end

  bfr_hdr_det u_hdr_det (
    .clk     (clk),
    .rst     (rst),
    .ctl     (hdr_ctl),
    .rx_byte (rx_byte),
    .match   (hdr_match)
  );

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    result           = 1'b0;
    unique case (phase)
      PH_PAYLOAD: begin
        running_sum_next = running_sum + rx_byte;
        byte_count_next  = byte_count + 1'b1;
        if (byte_count_next == COUNT_W'(PAYLOAD_LEN)) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        result           = 1'b1;
        phase_next       = PH_HUNT;
        byte_count_next  = '0;
        running_sum_next = 8'd0;
      end
      default: begin
        phase_next = PH_HUNT;
        if (hdr_match) begin
          phase_next       = PH_PAYLOAD;
          byte_count_next  = '0;
          running_sum_next = header_sum();
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= '0;
      running_sum <= 8'd0;
      saved       <= '0;
      out_valid   <= 1'b0;
      frame_ok    <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(accept && result)) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        phase       <= phase_next;
        byte_count  <= byte_count_next;
        running_sum <= running_sum_next;
        if (result) begin
          out_valid <= 1'b1;
          frame_ok  <= sum_ok;
          if (sum_ok) begin
            saved <= payload;
          end
        end
      end
    end
  end

  // payload shifts in from the top; after 24 bytes byte i sits at bits [8i+7:8i]
  always_ff @(posedge clk) begin
    if (accept && phase == PH_PAYLOAD) begin
      payload <= {rx_byte, payload[8*PAYLOAD_LEN-1:8]};
    end
  end

  // stored words only change on a transfer, so they are stable while a result waits
  assign total_raw      = saved[31:0];
  assign capacity_raw   = saved[63:32];
  assign used_raw       = saved[95:64];
  assign percentage_raw = saved[127:96];
  assign current_raw    = saved[159:128];
  assign voltage_raw    = saved[191:160];

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (byte_count < COUNT_W'(PAYLOAD_LEN)))
    else $error("payload count out of range");

  a_hunt_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (byte_count == '0 && running_sum == 8'd0))
    else $error("count or sum not cleared while hunting");

  a_result_on_check: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_CHECK) |=> out_valid)
    else $error("checksum byte gave no result");

  a_words_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && phase != PH_CHECK) |=> $stable(saved))
    else $error("stored words changed outside a frame end");

  a_no_result_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(accept && phase == PH_CHECK)) |=> !out_valid)
    else $error("result without checksum byte");

endmodule

`default_nettype wire

>>> dv/battery_frame_receiver_test.sv
// Self-checking testbench for the battery frame receiver: byte stream stimulus and frame tracking.
`default_nettype none

module battery_frame_receiver_test;
  import bfr_pkg::*;

  localparam int unsigned GAP_PCT     = 29;
  localparam int unsigned FRAME_ITEMS = 1950;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic                        ok;
    logic [WORD_COUNT-1:0][31:0] words;
  } frame_report_t;

  typedef logic [PAYLOAD_LEN-1:0][7:0] payload_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        frame_ok;
  logic [31:0] total_raw;
  logic [31:0] capacity_raw;
  logic [31:0] used_raw;
  logic [31:0] percentage_raw;
  logic [31:0] current_raw;
  logic [31:0] voltage_raw;

  bit          steady      = 1'b0;
  int unsigned mismatches  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_bytes  = 0;

  frame_report_t pending_reports [$];

  // Frame tracker state
  logic [63:0] hunt_window;
  phase_t      rx_phase;
  logic [4:0]  payload_seen;
  logic [7:0]  frame_sum;
  logic [7:0]  payload_buf [PAYLOAD_LEN];
  logic [31:0] good_words [WORD_COUNT];

  string word_name [WORD_COUNT] = '{"total_raw", "capacity_raw", "used_raw",
                                    "percentage_raw", "current_raw", "voltage_raw"};

  battery_frame_receiver dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_ok       (frame_ok),
    .total_raw      (total_raw),
    .capacity_raw   (capacity_raw),
    .used_raw       (used_raw),
    .percentage_raw (percentage_raw),
    .current_raw    (current_raw),
    .voltage_raw    (voltage_raw)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  // Advances the tracker by one transferred byte; queues a report on the checksum byte.
  task automatic track_byte(input logic [7:0] b);
    frame_report_t rep;
    logic [7:0]    want_chk;
    int            k;
    case (rx_phase)
      PH_PAYLOAD: begin
        payload_buf[payload_seen] = b;
        frame_sum = frame_sum + b;
        payload_seen = payload_seen + 5'd1;
        if (payload_seen == PAYLOAD_LEN) rx_phase = PH_CHECK;
      end
      PH_CHECK: begin
        want_chk = 8'd0 - frame_sum;
        rep.ok = (b == want_chk);
        for (k = 0; k < WORD_COUNT; k++) begin
          if (rep.ok) begin
            good_words[k] = {payload_buf[4*k+3], payload_buf[4*k+2],
                             payload_buf[4*k+1], payload_buf[4*k]};
          end
          rep.words[k] = good_words[k];
        end
        pending_reports.push_back(rep);
        rx_phase     = PH_HUNT;
        payload_seen = '0;
        frame_sum    = '0;
        hunt_window  = '0;
      end
      default: begin
        rx_phase    = PH_HUNT;
        hunt_window = {hunt_window[55:0], b};
        if (hunt_window == HEADER_WORD) begin
          // window is cleared so header bytes never feed a later match
          rx_phase     = PH_PAYLOAD;
          payload_seen = '0;
          hunt_window  = '0;
          frame_sum    = '0;
          for (k = 0; k < HEADER_LEN; k++) frame_sum = frame_sum + HEADER_WORD[8*k +: 8];
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    track_byte(b);
    sent_bytes++;
  endtask

  // Header bytes first..last-1, in transfer order.
  task automatic send_header_span(input int first, input int last);
    int i;
    for (i = first; i < last; i++) send_byte(HEADER_WORD[8*(HEADER_LEN-1-i) +: 8]);
  endtask

  task automatic send_frame(input payload_t pl, input logic corrupt);
    logic [7:0] sum;
    logic [7:0] chk;
    int         i;
    sum = '0;
    for (i = 0; i < HEADER_LEN; i++) sum = sum + HEADER_WORD[8*i +: 8];
    send_header_span(0, HEADER_LEN);
    for (i = 0; i < PAYLOAD_LEN; i++) begin
      sum = sum + pl[i];
      send_byte(pl[i]);
    end
    chk = 8'd0 - sum;
    if (corrupt) chk = chk ^ 8'($urandom_range(255, 1));
    send_byte(chk);
  endtask

  function automatic logic [7:0] noise_byte();
    int sel;
    sel = $urandom_range(HEADER_LEN - 1);
    if ($urandom_range(1)) return HEADER_WORD[8*sel +: 8];
    return 8'($urandom);
  endfunction

  function automatic payload_t random_payload();
    payload_t pl;
    int       i;
    int       style;
    style = $urandom_range(3);
    for (i = 0; i < PAYLOAD_LEN; i++) begin
      case (style)
        0:       pl[i] = noise_byte();
        1:       pl[i] = $urandom_range(1) ? 8'hFF : 8'h00;
        default: pl[i] = 8'($urandom);
      endcase
    end
    return pl;
  endfunction

  task automatic test_bad_checksum_before_good;
    send_frame(random_payload(), 1'b1);
  endtask

  task automatic test_extreme_payloads;
    send_frame('0, 1'b0);
    send_frame('1, 1'b0);
    // bad frame must leave the all-ones words in place
    send_frame({PAYLOAD_LEN{8'h5A}}, 1'b1);
  endtask

  task automatic test_resync_and_trailing;
    payload_t pl;
    int       i;
    send_header_span(0, 6);
    pl = random_payload();
    // header text inside the payload is plain data
    for (i = 0; i < HEADER_LEN; i++) pl[16+i] = HEADER_WORD[8*(HEADER_LEN-1-i) +: 8];
    send_frame(pl, 1'b0);
    // tail of a header straight after the checksum must not sync
    send_header_span(1, HEADER_LEN);
    send_byte(8'h55);
    send_frame(random_payload(), 1'b0);
  endtask

  task automatic test_random_traffic;
    int unsigned frames;
    int          n;
    int          i;
    frames = 0;
    while (sent_bytes + HEADER_LEN + PAYLOAD_LEN + 1 <= FRAME_ITEMS) begin
      steady = (frames >= 20 && frames < 32);
      case ($urandom_range(9))
        0: begin
          n = $urandom_range(6, 1);
          for (i = 0; i < n; i++) send_byte(noise_byte());
        end
        1: begin
          send_header_span(0, $urandom_range(HEADER_LEN - 1, 1));
          send_byte(noise_byte());
        end
        default: ;
      endcase
      send_frame(random_payload(), $urandom_range(99) < 25);
      frames++;
    end
    steady = 1'b0;
  endtask

  // Result side: compare each transfer with the oldest pending report, then stall at random unless steady.
  always @(posedge clk) begin : take_result
    frame_report_t               want;
    logic [WORD_COUNT-1:0][31:0] got_words;
    int                          k;
    if (!rst && out_valid && out_ready) begin
      got_words = {voltage_raw, current_raw, percentage_raw, used_raw, capacity_raw, total_raw};
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with no frame pending", 32'(frame_ok), 32'd0);
      end else begin
        want = pending_reports.pop_front();
        if (frame_ok !== want.ok) flag_mismatch("frame_ok", 32'(frame_ok), 32'(want.ok));
        for (k = 0; k < WORD_COUNT; k++) begin
          if (got_words[k] !== want.words[k]) begin
            flag_mismatch(word_name[k], got_words[k], want.words[k]);
          end
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= GAP_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < STALL_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int k;
    hunt_window  = '0;
    rx_phase     = PH_HUNT;
    payload_seen = '0;
    frame_sum    = '0;
    for (k = 0; k < PAYLOAD_LEN; k++) payload_buf[k] = '0;
    for (k = 0; k < WORD_COUNT; k++) good_words[k] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_bad_checksum_before_good();
    test_extreme_payloads();
    test_resync_and_trailing();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
